// ===== src/q2t_pkg.sv =====
// Shared types and constants for the quad to trapezoid band splitter.
// No dependencies; used by the front, queue, back and top level modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package q2t_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One row of merged corners: y and the leftmost/rightmost x
  typedef struct packed {
    logic signed [31:0] ry;
    logic signed [31:0] rl;
    logic signed [31:0] rr;
  } row_t;

  // Classified shape: number of distinct rows (1..4) and the rows sorted by y
  typedef struct packed {
    logic [2:0]       n;
    row_t [3:0]       rows;
  } rowset_t;

  // One result beat
  typedef struct packed {
    logic               valid;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
    logic signed [31:0] lt;
    logic signed [31:0] lb;
    logic signed [31:0] rt;
    logic signed [31:0] rb;
    logic [1:0]         count;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/q2t_front.sv =====
// Front part: corner mapping through the affine transform and row classification.
// Five register stages, one item per cycle; depends on q2t_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q2t_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic signed [15:0] rect_left_i,
  input  wire logic signed [15:0] rect_top_i,
  input  wire logic [15:0]        rect_width_i,
  input  wire logic [15:0]        rect_height_i,
  input  wire logic signed [31:0] coef_xx_i,
  input  wire logic signed [31:0] coef_xy_i,
  input  wire logic signed [31:0] coef_yx_i,
  input  wire logic signed [31:0] coef_yy_i,
  input  wire logic signed [31:0] offset_x_i,
  input  wire logic signed [31:0] offset_y_i,
  output logic                    push_o,
  output q2t_pkg::rowset_t        rows_o
);

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Stage 1: the eight partial products
  logic signed [16:0] w_s, h_s;
  logic signed [47:0] p_xx_x_d, p_xy_y_d, p_yx_x_d, p_yy_y_d;
  logic signed [48:0] p_xx_w_d, p_xy_h_d, p_yx_w_d, p_yy_h_d;
  logic               v1_q;
  logic signed [47:0] p_xx_x_q, p_xy_y_q, p_yx_x_q, p_yy_y_q;
  logic signed [48:0] p_xx_w_q, p_xy_h_q, p_yx_w_q, p_yy_h_q;

  assign w_s      = $signed({1'b0, rect_width_i});
  assign h_s      = $signed({1'b0, rect_height_i});
  assign p_xx_x_d = coef_xx_i * rect_left_i;
  assign p_xy_y_d = coef_xy_i * rect_top_i;
  assign p_yx_x_d = coef_yx_i * rect_left_i;
  assign p_yy_y_d = coef_yy_i * rect_top_i;
  assign p_xx_w_d = coef_xx_i * w_s;
  assign p_xy_h_d = coef_xy_i * h_s;
  assign p_yx_w_d = coef_yx_i * w_s;
  assign p_yy_h_d = coef_yy_i * h_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xx_x_q <= p_xx_x_d;
    p_xy_y_q <= p_xy_y_d;
    p_yx_x_q <= p_yx_x_d;
    p_yy_y_q <= p_yy_y_d;
    p_xx_w_q <= p_xx_w_d;
    p_xy_h_q <= p_xy_h_d;
    p_yx_w_q <= p_yx_w_d;
    p_yy_h_q <= p_yy_h_d;
  end

  // Stage 2: base corner position, size terms carried along
  logic               v2_q;
  logic signed [51:0] bx_q, by_q;
  logic signed [51:0] wx_q, hx_q, wy_q, hy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q <= 52'(p_xx_x_q) + 52'(p_xy_y_q) + 52'(offset_x_i);
    by_q <= 52'(p_yx_x_q) + 52'(p_yy_y_q) + 52'(offset_y_i);
    wx_q <= 52'(p_xx_w_q);
    hx_q <= 52'(p_xy_h_q);
    wy_q <= 52'(p_yx_w_q);
    hy_q <= 52'(p_yy_h_q);
  end

  // Stage 3: four corners; bit 1 of the corner index adds width, bit 0 height
  logic               v3_q;
  logic signed [31:0] gx_d [4];
  logic signed [31:0] gy_d [4];
  logic signed [31:0] gx_q [4];
  logic signed [31:0] gy_q [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      gx_d[c] = sat32(bx_q + (c[1] ? wx_q : 52'sd0) + (c[0] ? hx_q : 52'sd0));
      gy_d[c] = sat32(by_q + (c[1] ? wy_q : 52'sd0) + (c[0] ? hy_q : 52'sd0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q <= gx_d;
    gy_q <= gy_d;
  end

  // Stage 4: rank each corner among the distinct y values
  logic [3:0]         first_d;
  logic [1:0]         rank_d [4];
  logic [2:0]         n_d;
  logic               v4_q;
  logic [1:0]         rank_q [4];
  logic [2:0]         n_q;
  logic signed [31:0] gx4_q [4];
  logic signed [31:0] gy4_q [4];

  always_comb begin
    n_d = 3'd0;
    for (int i = 0; i < 4; i++) begin
      first_d[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (gy_q[j] == gy_q[i]) begin
          first_d[i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      rank_d[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (first_d[j] && (gy_q[j] < gy_q[i])) begin
          rank_d[i] = rank_d[i] + 2'd1;
        end
      end
      n_d = n_d + {2'd0, first_d[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    n_q    <= n_d;
    gx4_q  <= gx_q;
    gy4_q  <= gy_q;
  end

  // Stage 5: merge corners of one rank into a row
  q2t_pkg::rowset_t rows_d;
  logic             found;

  always_comb begin
    rows_d   = '0;
    rows_d.n = n_q;
    for (int r = 0; r < 4; r++) begin
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (rank_q[i] == 2'(r)) begin
          if (!found) begin
            rows_d.rows[r].ry = gy4_q[i];
            rows_d.rows[r].rl = gx4_q[i];
            rows_d.rows[r].rr = gx4_q[i];
            found = 1'b1;
          end else begin
            if (gx4_q[i] < rows_d.rows[r].rl) rows_d.rows[r].rl = gx4_q[i];
            if (gx4_q[i] > rows_d.rows[r].rr) rows_d.rows[r].rr = gx4_q[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_o <= 1'b0;
    end else begin
      push_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_o <= rows_d;
  end

endmodule

`default_nettype wire

// ===== src/q2t_fifo.sv =====
// Short queue of classified shapes between the front and the back part.
// Depends on q2t_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module q2t_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  q2t_pkg::rowset_t      data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output q2t_pkg::rowset_t      data_o
);

  q2t_pkg::rowset_t                   mem_q [q2t_pkg::FIFO_DEPTH];
  logic [q2t_pkg::FIFO_PW-1:0]        wptr_q, rptr_q;
  logic [q2t_pkg::FIFO_CW-1:0]        cnt_q;

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== src/q2t_back.sv =====
// Back part: edge interpolation for the three-band case and band emission.
// Two 32-step restoring dividers run side by side; depends on q2t_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q2t_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  q2t_pkg::rowset_t      rows_i,
  output logic                  pop_o,
  output q2t_pkg::res_t         res_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_EMIT} state_e;

  state_e             state_q;
  q2t_pkg::rowset_t   cur_q;
  logic [1:0]         k_q;
  logic [4:0]         it_q;
  logic signed [31:0] xs0_q, xs1_q, t0_q, t1_q;
  logic               neg0_q, neg1_q;
  logic [31:0]        mag0_q, mag1_q, num0_q, num1_q, den0_q, den1_q;
  logic [31:0]        rem0_q, rem1_q, low0_q, low1_q;
  logic               valid_q;
  q2t_pkg::res_t      res_q;

  // Edge set-up from the queue head
  logic signed [32:0] dx0, dx1;
  logic [32:0]        mg0, mg1;
  assign dx0 = 33'(rows_i.rows[2].rl) - 33'(rows_i.rows[0].rl);
  assign dx1 = 33'(rows_i.rows[3].rl) - 33'(rows_i.rows[1].rl);
  assign mg0 = dx0[32] ? 33'(-dx0) : 33'(dx0);
  assign mg1 = dx1[32] ? 33'(-dx1) : 33'(dx1);

  // Band selection
  logic [1:0]  cnt;
  logic        last;
  logic [1:0]  k_last;
  logic        load;
  q2t_pkg::res_t band;

  always_comb begin
    case (cur_q.n)
      3'd2:    cnt = 2'd1;
      3'd3:    cnt = 2'd2;
      3'd4:    cnt = 2'd3;
      default: cnt = 2'd0;
    endcase
    k_last = (cnt == 2'd0) ? 2'd0 : cnt - 2'd1;
    last   = (k_q == k_last);
  end

  always_comb begin
    logic signed [31:0] x0, x1, x2, x3;
    logic               nar;
    x0  = cur_q.rows[0].rl;
    x1  = cur_q.rows[1].rl;
    x2  = cur_q.rows[2].rl;
    x3  = cur_q.rows[3].rl;
    nar = (x1 < x2);
    band        = '0;
    band.valid  = 1'b1;
    band.count  = cnt;
    band.last   = last;
    if (cnt != 2'd0) begin
      band.top    = cur_q.rows[k_q].ry;
      band.bottom = cur_q.rows[2'(k_q + 2'd1)].ry;
    end
    case (cnt)
      2'd1: begin
        band.lt = x0;
        band.lb = x1;
        band.rt = cur_q.rows[0].rr;
        band.rb = cur_q.rows[1].rr;
      end
      2'd2: begin
        if (k_q == 2'd0) begin
          band.lt = x0;
          band.lb = x1;
          band.rt = x0;
          band.rb = cur_q.rows[1].rr;
        end else begin
          band.lt = x1;
          band.lb = x2;
          band.rt = cur_q.rows[1].rr;
          band.rb = x2;
        end
      end
      2'd3: begin
        case (k_q)
          2'd0: begin
            band.lt = x0;
            band.lb = nar ? x1 : t0_q;
            band.rt = x0;
            band.rb = nar ? t0_q : x1;
          end
          2'd1: begin
            band.lt = nar ? x1 : t0_q;
            band.lb = nar ? t1_q : x2;
            band.rt = nar ? t0_q : x1;
            band.rb = nar ? x2 : t1_q;
          end
          default: begin
            band.lt = nar ? t1_q : x2;
            band.lb = x3;
            band.rt = nar ? x2 : t1_q;
            band.rb = x3;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign load  = !empty_i && ((state_q == ST_IDLE) || ((state_q == ST_EMIT) && last));
  assign pop_o = load;

  // Divider step: shift in one dividend bit, subtract where it fits
  logic [32:0] tr0, tr1;
  logic        ge0, ge1;
  assign tr0 = {rem0_q, low0_q[31]};
  assign tr1 = {rem1_q, low1_q[31]};
  assign ge0 = (tr0 >= {1'b0, den0_q});
  assign ge1 = (tr1 >= {1'b0, den1_q});

  logic [63:0] prod0, prod1;
  assign prod0 = mag0_q * num0_q;
  assign prod1 = mag1_q * num1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= 2'd0;
      it_q    <= 5'd0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_MUL: begin
          state_q <= ST_DIV;
          it_q    <= 5'd0;
        end
        ST_DIV: begin
          it_q <= it_q + 5'd1;
          if (it_q == 5'd31) state_q <= ST_FIX;
        end
        ST_FIX: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          valid_q <= 1'b1;
          k_q     <= k_q + 2'd1;
          if (last) state_q <= ST_IDLE;
        end
        default: ;
      endcase
      if (load) begin
        k_q     <= 2'd0;
        state_q <= (rows_i.n == 3'd4) ? ST_MUL : ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= rows_i;
      xs0_q  <= rows_i.rows[0].rl;
      xs1_q  <= rows_i.rows[1].rl;
      neg0_q <= dx0[32];
      neg1_q <= dx1[32];
      mag0_q <= mg0[31:0];
      mag1_q <= mg1[31:0];
      num0_q <= 32'(rows_i.rows[1].ry - rows_i.rows[0].ry);
      num1_q <= 32'(rows_i.rows[2].ry - rows_i.rows[1].ry);
      den0_q <= 32'(rows_i.rows[2].ry - rows_i.rows[0].ry);
      den1_q <= 32'(rows_i.rows[3].ry - rows_i.rows[1].ry);
    end
    if (state_q == ST_MUL) begin
      // quotient fits 32 bits, so the upper half already lies below the divisor
      rem0_q <= prod0[63:32];
      low0_q <= prod0[31:0];
      rem1_q <= prod1[63:32];
      low1_q <= prod1[31:0];
    end
    if (state_q == ST_DIV) begin
      rem0_q <= ge0 ? 32'(tr0 - {1'b0, den0_q}) : tr0[31:0];
      rem1_q <= ge1 ? 32'(tr1 - {1'b0, den1_q}) : tr1[31:0];
      low0_q <= {low0_q[30:0], ge0};
      low1_q <= {low1_q[30:0], ge1};
    end
    if (state_q == ST_FIX) begin
      t0_q <= neg0_q ? xs0_q - $signed(low0_q) : xs0_q + $signed(low0_q);
      t1_q <= neg1_q ? xs1_q - $signed(low1_q) : xs1_q + $signed(low1_q);
    end
    if (state_q == ST_EMIT) begin
      res_q <= band;
    end
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== src/quad_to_trapezoid_split_top.sv =====
// Quad to trapezoid band splitter: affine corner mapping, row merge and band output.
// Path: the front pipeline, the shape queue, then the back part, which registers each band.
// Bands leave at one per cycle while the back part emits; a three-band item first passes
// the multiply, 32-step edge divide and fix-up states, during which no band leaves.
// busy_o rises when eight accepted items are not yet taken by the back part.
// Results cannot be stalled. Reset is asynchronous, active low, restores the identity map.
`timescale 1ns / 1ps
`default_nettype none

module quad_to_trapezoid_split_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [15:0] rect_left_i,
  input  wire logic signed [15:0] rect_top_i,
  input  wire logic [15:0]        rect_width_i,
  input  wire logic [15:0]        rect_height_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  output logic                    res_valid_o,
  output logic signed [31:0]      band_top_o,
  output logic signed [31:0]      band_bottom_o,
  output logic signed [31:0]      left_top_x_o,
  output logic signed [31:0]      left_bottom_x_o,
  output logic signed [31:0]      right_top_x_o,
  output logic signed [31:0]      right_bottom_x_o,
  output logic [1:0]              band_count_o,
  output logic                    last_band_o
);

  localparam logic [2:0] REG_COEF_XX  = 3'd0;
  localparam logic [2:0] REG_COEF_XY  = 3'd1;
  localparam logic [2:0] REG_COEF_YX  = 3'd2;
  localparam logic [2:0] REG_COEF_YY  = 3'd3;
  localparam logic [2:0] REG_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q, offset_x_q, offset_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= ONE_FX;
      coef_xy_q  <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= ONE_FX;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_XX:  coef_xx_q  <= cfg_data_i;
        REG_COEF_XY:  coef_xy_q  <= cfg_data_i;
        REG_COEF_YX:  coef_yx_q  <= cfg_data_i;
        REG_COEF_YY:  coef_yy_q  <= cfg_data_i;
        REG_OFFSET_X: offset_x_q <= cfg_data_i;
        REG_OFFSET_Y: offset_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Credit count: items accepted and not yet taken from the queue
  logic                         take, pop, push, empty;
  logic [q2t_pkg::FIFO_CW-1:0]  inflight_q;
  q2t_pkg::rowset_t             push_rows, head_rows;
  q2t_pkg::res_t                res;

  assign busy_o = (inflight_q == q2t_pkg::FIFO_CW'(q2t_pkg::FIFO_DEPTH));
  assign take   = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (take && !pop) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (pop && !take) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  q2t_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .coef_xx_i     (coef_xx_q),
    .coef_xy_i     (coef_xy_q),
    .coef_yx_i     (coef_yx_q),
    .coef_yy_i     (coef_yy_q),
    .offset_x_i    (offset_x_q),
    .offset_y_i    (offset_y_q),
    .push_o        (push),
    .rows_o        (push_rows)
  );

  q2t_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rows),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_rows)
  );

  q2t_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .rows_i  (head_rows),
    .pop_o   (pop),
    .res_o   (res)
  );

  assign res_valid_o      = res.valid;
  assign band_top_o       = res.top;
  assign band_bottom_o    = res.bottom;
  assign left_top_x_o     = res.lt;
  assign left_bottom_x_o  = res.lb;
  assign right_top_x_o    = res.rt;
  assign right_bottom_x_o = res.rb;
  assign band_count_o     = res.count;
  assign last_band_o      = res.last;

endmodule

`default_nettype wire

// ===== src/q2t_check.sv =====
// Port-level checks on the band splitter's result stream, bound to the top level.
// Depends on quad_to_trapezoid_split_top port names only.
`timescale 1ns / 1ps
`default_nettype none

module q2t_check (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               res_valid_o,
  input wire logic signed [31:0] band_top_o,
  input wire logic signed [31:0] band_bottom_o,
  input wire logic signed [31:0] left_top_x_o,
  input wire logic signed [31:0] left_bottom_x_o,
  input wire logic signed [31:0] right_top_x_o,
  input wire logic signed [31:0] right_bottom_x_o,
  input wire logic [1:0]         band_count_o,
  input wire logic               last_band_o
);

  // a degenerate shape is one closing beat
  a_degen_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (band_count_o == 2'd0) |-> last_band_o)
    else $error("degenerate beat without last_band");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (band_count_o == 2'd0) |->
      (band_top_o == 0) && (band_bottom_o == 0) && (left_top_x_o == 0) &&
      (left_bottom_x_o == 0) && (right_top_x_o == 0) && (right_bottom_x_o == 0))
    else $error("degenerate beat with non-zero coordinates");

  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (band_count_o != 2'd0) |-> (band_top_o < band_bottom_o))
    else $error("band top not above band bottom");

  // bands of one shape come back to back and stack without gaps
  a_band_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_band_o |=>
      res_valid_o && (band_top_o == $past(band_bottom_o)) &&
      (band_count_o == $past(band_count_o)))
    else $error("band stack broken");

endmodule

bind quad_to_trapezoid_split_top q2t_check u_q2t_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_o      (res_valid_o),
  .band_top_o       (band_top_o),
  .band_bottom_o    (band_bottom_o),
  .left_top_x_o     (left_top_x_o),
  .left_bottom_x_o  (left_bottom_x_o),
  .right_top_x_o    (right_top_x_o),
  .right_bottom_x_o (right_bottom_x_o),
  .band_count_o     (band_count_o),
  .last_band_o      (last_band_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for quad_to_trapezoid_split_top: rectangles in, trapezoid bands out.
// Depends on q2t_pkg and the top level; predicts bands in a local scoreboard class.
`timescale 1ns / 1ps

module testbench;

  localparam int REG_XX  = 0;
  localparam int REG_XY  = 1;
  localparam int REG_YX  = 2;
  localparam int REG_YY  = 3;
  localparam int REG_OFX = 4;
  localparam int REG_OFY = 5;
  localparam int REG_NUM = 6;
  localparam int REG_TOP = 7;
  localparam int ONE     = 65536;
  localparam int SETTLE  = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] rect_left_i = '0;
  logic signed [15:0] rect_top_i = '0;
  logic [15:0]        rect_width_i = '0;
  logic [15:0]        rect_height_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               res_valid_o;
  logic signed [31:0] band_top_o, band_bottom_o, left_top_x_o, left_bottom_x_o;
  logic signed [31:0] right_top_x_o, right_bottom_x_o;
  logic [1:0]         band_count_o;
  logic               last_band_o;

  quad_to_trapezoid_split_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class band_scoreboard;
    longint            xform[REG_NUM];
    q2t_pkg::res_t     bands_due[$];
    int                errors = 0;

    function void reset_regs();
      xform = '{ONE, 0, 0, ONE, 0, 0};
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      if (idx < REG_NUM) xform[idx] = longint'($signed(v));
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // x along an edge at num/den of its height, offset truncated toward zero
    function longint edge_x(longint xs, longint xe, longint num, longint den);
      longint dx;
      longint unsigned mag, q;
      dx  = xe - xs;
      mag = (dx < 0) ? longint'(-dx) : dx;
      q   = mag * longint'(num) / longint'(den);
      return (dx < 0) ? xs - longint'(q) : xs + longint'(q);
    endfunction

    function void push_band(longint tp, longint bt, longint lt, longint lb,
                            longint rt, longint rb, int cnt, bit lst);
      q2t_pkg::res_t b;
      b.valid  = 1'b1;
      b.top    = tp[31:0];
      b.bottom = bt[31:0];
      b.lt     = lt[31:0];
      b.lb     = lb[31:0];
      b.rt     = rt[31:0];
      b.rb     = rb[31:0];
      b.count  = cnt[1:0];
      b.last   = lst;
      bands_due.push_back(b);
    endfunction

    function void note_rect(logic signed [15:0] l, logic signed [15:0] t,
                            logic [15:0] w, logic [15:0] h);
      longint cx[4], cy[4], ry[5], rl[5], rr[5];
      longint gx, gy, t0, t1;
      int     n;
      bit     done;
      n = 0;
      cx[0] = l;              cy[0] = t;
      cx[1] = l;              cy[1] = t + longint'(h);
      cx[2] = l + longint'(w); cy[2] = t;
      cx[3] = l + longint'(w); cy[3] = t + longint'(h);
      for (int i = 0; i < 4; i++) begin
        gx = sat32(xform[REG_XX] * cx[i] + xform[REG_XY] * cy[i] + xform[REG_OFX]);
        gy = sat32(xform[REG_YX] * cx[i] + xform[REG_YY] * cy[i] + xform[REG_OFY]);
        done = 1'b0;
        for (int j = 0; j < n && !done; j++) begin
          if (gy < ry[j]) begin
            for (int k = n - 1; k >= j; k--) begin
              ry[k+1] = ry[k]; rl[k+1] = rl[k]; rr[k+1] = rr[k];
            end
            ry[j] = gy; rl[j] = gx; rr[j] = gx;
            n++;
            done = 1'b1;
          end else if (gy == ry[j]) begin
            if (gx < rl[j]) rl[j] = gx;
            if (gx > rr[j]) rr[j] = gx;
            done = 1'b1;
          end
        end
        if (!done) begin
          ry[n] = gy; rl[n] = gx; rr[n] = gx;
          n++;
        end
      end
      case (n)
        2: push_band(ry[0], ry[1], rl[0], rl[1], rr[0], rr[1], 1, 1'b1);
        3: begin
          push_band(ry[0], ry[1], rl[0], rl[1], rl[0], rr[1], 2, 1'b0);
          push_band(ry[1], ry[2], rl[1], rl[2], rr[1], rl[2], 2, 1'b1);
        end
        4: begin
          t0 = edge_x(rl[0], rl[2], ry[1] - ry[0], ry[2] - ry[0]);
          t1 = edge_x(rl[1], rl[3], ry[2] - ry[1], ry[3] - ry[1]);
          if (rl[1] < rl[2]) begin
            push_band(ry[0], ry[1], rl[0], rl[1], rl[0], t0, 3, 1'b0);
            push_band(ry[1], ry[2], rl[1], t1, t0, rl[2], 3, 1'b0);
            push_band(ry[2], ry[3], t1, rl[3], rl[2], rl[3], 3, 1'b1);
          end else begin
            push_band(ry[0], ry[1], rl[0], t0, rl[0], rl[1], 3, 1'b0);
            push_band(ry[1], ry[2], t0, rl[2], rl[1], t1, 3, 1'b0);
            push_band(ry[2], ry[3], rl[2], rl[3], t1, rl[3], 3, 1'b1);
          end
        end
        default: push_band(0, 0, 0, 0, 0, 0, 0, 1'b1);
      endcase
    endfunction

    function void check_band(q2t_pkg::res_t got);
      q2t_pkg::res_t want;
      if (bands_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected band: %p", got);
        return;
      end
      want = bands_due.pop_front();
      if (got.top !== want.top || got.bottom !== want.bottom || got.lt !== want.lt ||
          got.lb !== want.lb || got.rt !== want.rt || got.rb !== want.rb ||
          got.count !== want.count || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("band mismatch at %0t", $time);
          $display("  exp top %h bot %h lt %h lb %h rt %h rb %h cnt %0d last %0d",
                   want.top, want.bottom, want.lt, want.lb, want.rt, want.rb,
                   want.count, want.last);
          $display("  got top %h bot %h lt %h lb %h rt %h rb %h cnt %0d last %0d",
                   got.top, got.bottom, got.lt, got.lb, got.rt, got.rb,
                   got.count, got.last);
        end
      end
    endfunction
  endclass

  band_scoreboard sb = new;

  always @(posedge clk_i) begin
    q2t_pkg::res_t got;
    if (rst_ni) begin
      if (res_valid_o) begin
        got = '{1'b1, band_top_o, band_bottom_o, left_top_x_o, left_bottom_x_o,
                right_top_x_o, right_bottom_x_o, band_count_o, last_band_o};
        sb.check_band(got);
      end
      if (start_i && !busy_o)
        sb.note_rect(rect_left_i, rect_top_i, rect_width_i, rect_height_i);
    end
  end

  // Present one rectangle and hold it until accepted; start stays high afterwards
  task automatic send_rect(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h);
    rect_left_i   <= l;
    rect_top_i    <= t;
    rect_width_i  <= w;
    rect_height_i <= h;
    start_i       <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending, let every expected band arrive, then settle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.bands_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(int idx, logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[2:0];
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic load_xform(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                            logic [31:0] yy, logic [31:0] ox, logic [31:0] oy);
    drain();
    cfg_write(REG_XX, xx);
    cfg_write(REG_XY, xy);
    cfg_write(REG_YX, yx);
    cfg_write(REG_YY, yy);
    cfg_write(REG_OFX, ox);
    cfg_write(REG_OFY, oy);
  endtask

  function automatic logic [15:0] rnd_field();
    if ($urandom_range(3) == 0) return 16'($urandom_range(40));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(4))
      0: return 32'($signed($urandom_range(4 * ONE)) - 2 * ONE);
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_rects(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 8)) begin
        send_rect(rnd_field(), rnd_field(), rnd_field(), rnd_field());
        sent++;
      end
      if ($urandom_range(2) != 0) idle($urandom_range(0, 12));
    end
  endtask

  initial begin
    sb.reset_regs();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity: degenerate point, line, ordinary box, saturating extremes
    send_rect(16'd0, 16'd0, 16'd0, 16'd0);
    send_rect(16'd5, 16'd7, 16'd0, 16'd9);
    send_rect(16'd3, 16'd4, 16'd10, 16'd0);
    send_rect(16'd1, 16'd2, 16'd3, 16'd4);
    send_rect(16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    send_rect(16'h7fff, 16'h8000, 16'hffff, 16'hffff);
    send_rect(16'hffff, 16'hffff, 16'h0001, 16'h0001);
    // hold off until every band is back, then use invalid indexes
    drain();
    cfg_write(REG_NUM, 32'hdeadbeef);
    cfg_write(REG_TOP, 32'h12345678);
    send_rect(16'd2, 16'd2, 16'd4, 16'd4);

    // 45 degree style map: squares become diamonds, others three bands unless saturation merges rows
    load_xform(ONE, -ONE, ONE, ONE, 32'h0010_0000, 32'hfff0_0000);
    send_rect(16'd0, 16'd0, 16'd8, 16'd8);
    send_rect(16'hfffb, 16'd3, 16'd20, 16'd20);
    send_rect(16'd0, 16'd0, 16'd10, 16'd3);
    send_rect(16'd0, 16'd0, 16'd3, 16'd10);
    send_rect(16'h8000, 16'h8000, 16'hffff, 16'h0007);

    // shear both ways for either split orientation, with odd fractions
    load_xform(32'h0001_8000, 32'h0000_3333, 32'h0000_8001, ONE, 0, 0);
    send_rect(16'd1, 16'd1, 16'd7, 16'd5);
    send_rect(16'hfff0, 16'd9, 16'd13, 16'd3);
    load_xform(ONE, 32'hffff_a000, 32'hffff_5555, ONE, 32'h7fffffff, 32'h80000000);
    send_rect(16'd1, 16'd1, 16'd7, 16'd5);
    send_rect(16'd100, 16'hff00, 16'd1, 16'd300);

    // flattened y: every shape degenerate
    load_xform(32'h7fffffff, 32'h80000000, 0, 0, 32'h0000_1234, 32'h5555_aaaa);
    send_rect(16'd1, 16'd2, 16'd3, 16'd4);
    send_rect(16'h7fff, 16'h8000, 16'hffff, 16'hffff);

    // extreme coefficients with saturation everywhere
    load_xform(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h7fffffff);
    random_rects(25);

    load_xform(ONE, 0, 0, ONE, 0, 0);
    random_rects(30);
    load_xform(ONE, -ONE, ONE, ONE, 0, 0);
    random_rects(30);
    repeat (3) begin
      load_xform(rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), $urandom, $urandom);
      random_rects(22);
    end

    drain();
    if (sb.errors == 0 && sb.bands_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/q2t_pkg.sv
src/q2t_front.sv
src/q2t_fifo.sv
src/q2t_back.sv
src/quad_to_trapezoid_split_top.sv
src/q2t_check.sv
tb/testbench.sv
